>>> rtl/core/edf_tick_scheduler_unit_defines.svh
// Assertion macros shared by the EDF tick scheduler RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef EDF_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define EDF_TICK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EDFTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define EDFTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/edfts_pkg.sv
// Shared types and constants for the EDF tick scheduler.
// No dependencies; used by every module of the block.
package edfts_pkg;

	localparam int TIME_BITS     = 16;
	localparam int TTD_W         = TIME_BITS + 1;
	localparam int TICK_W        = 32;
	localparam int SLOT_FIELD_W  = 3;
	localparam int TASK_COUNT_W  = 4;
	localparam int MAX_SLOTS_DEF = 8;
	localparam int QUEUE_DEPTH   = 2;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	// Request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Register index, taken from paddr[2]
	localparam logic REG_TASK_COUNT = 1'b0;

	// Most negative time-to-deadline value
	localparam logic signed [TTD_W-1:0] TTD_MIN = {1'b1, {TIME_BITS{1'b0}}};

	typedef struct packed {
		logic                    req_type;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [TIME_BITS-1:0]    exec_time;
		logic [TIME_BITS-1:0]    rel_deadline;
		logic [TIME_BITS-1:0]    period;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] run_slot;
		logic                    idle;
		logic [TICK_W-1:0]       tick_time;
	} out_item_t;

	// Classified command passed from the front end to the engine
	typedef struct packed {
		logic                    req_type;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [TIME_BITS-1:0]    exec_time;
		logic [TIME_BITS-1:0]    rel_deadline;
		logic [TIME_BITS-1:0]    period;
	} cmd_t;

endpackage

>>> rtl/core/edfts_front.sv
// Front end of the EDF tick scheduler: accepts input transactions and classifies them.
// Depends on edfts_pkg; feeds edfts_queue.
module edfts_front #(
	parameter int MAX_SLOTS = edfts_pkg::MAX_SLOTS_DEF
) (
	input  logic                in_valid,
	output logic                in_stall,
	input  edfts_pkg::in_item_t in_item,
	input  logic                queue_full,
	output logic                push_valid,
	output edfts_pkg::cmd_t     push_cmd
);

	logic is_tick;
	logic slot_ok;

	// Classify: ticks always go on, loads only for slots that exist
	assign is_tick = (in_item.req_type == edfts_pkg::REQ_TICK);
	assign slot_ok = (32'(in_item.slot) < 32'(MAX_SLOTS));

	assign in_stall   = queue_full;
	assign push_valid = in_valid && (is_tick || slot_ok);

	// Build the command
	always_comb begin
		push_cmd.req_type     = in_item.req_type;
		push_cmd.slot         = in_item.slot;
		push_cmd.exec_time    = in_item.exec_time;
		push_cmd.rel_deadline = in_item.rel_deadline;
		push_cmd.period       = in_item.period;
	end

endmodule

>>> rtl/core/edfts_queue.sv
// Short command queue between the scheduler front end and its engine.
// Depends on edfts_pkg for the command type and depth.
module edfts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  edfts_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output edfts_pkg::cmd_t head_cmd
);

	localparam int DEPTH = edfts_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	edfts_pkg::cmd_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && !full;
	assign pop_fire   = pop && head_valid;

	// Store payload
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push_fire, pop_fire})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/edfts_engine.sv
// Back end of the EDF tick scheduler: task tables, release, selection tree and output register.
// Depends on edfts_pkg and edf_tick_scheduler_unit_defines.svh.
`include "edf_tick_scheduler_unit_defines.svh"

module edfts_engine #(
	parameter int MAX_SLOTS = edfts_pkg::MAX_SLOTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [edfts_pkg::TASK_COUNT_W-1:0]    task_count,
	input  logic                                  cmd_valid,
	input  edfts_pkg::cmd_t                       cmd,
	output logic                                  cmd_pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output edfts_pkg::out_item_t                  out_item
);

	localparam int TB     = edfts_pkg::TIME_BITS;
	localparam int TW     = edfts_pkg::TTD_W;
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int LEAVES = 1 << SLOT_W;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_PICK = 1'b1;

	logic                        state_q;
	logic [TB-1:0]               exec_q   [MAX_SLOTS];
	logic [TB-1:0]               dl_q     [MAX_SLOTS];
	logic [TB-1:0]               period_q [MAX_SLOTS];
	logic [TB-1:0]               phase_q  [MAX_SLOTS];
	logic [TB-1:0]               budget_q [MAX_SLOTS];
	logic signed [TW-1:0]        ttd_q    [MAX_SLOTS];
	logic [edfts_pkg::TICK_W-1:0] tick_q;
	logic                        out_valid_q;
	edfts_pkg::out_item_t        out_q;

	logic [MAX_SLOTS-1:0]        active;
	logic [MAX_SLOTS-1:0]        enabled;
	logic [MAX_SLOTS-1:0]        release_en;
	logic [MAX_SLOTS-1:0]        eligible;
	logic [TB:0]                 phase_inc [MAX_SLOTS];
	logic [TB-1:0]               phase_nxt [MAX_SLOTS];
	logic signed [TW-1:0]        ttd_nxt   [MAX_SLOTS];

	logic                        nd_v [2*LEAVES];
	logic signed [TW-1:0]        nd_t [2*LEAVES];
	logic [SLOT_W-1:0]           nd_i [2*LEAVES];
	logic                        found;
	logic [SLOT_W-1:0]           pick;

	logic                        is_load;
	logic [SLOT_W-1:0]           wr_slot;
	logic                        res_load;

	assign is_load  = (cmd.req_type == edfts_pkg::REQ_LOAD);
	assign wr_slot  = SLOT_W'(cmd.slot);
	assign cmd_pop  = (state_q == ST_RUN) && cmd_valid;
	assign res_load = (state_q == ST_PICK) && (!out_valid_q || !out_stall);

	// Per-slot status and next phase / deadline values
	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			active[i]     = (32'(task_count) > 32'(i));
			enabled[i]    = active[i] && (period_q[i] != '0);
			release_en[i] = enabled[i] && (phase_q[i] == '0);
			eligible[i]   = active[i] && (budget_q[i] != '0);
			phase_inc[i]  = {1'b0, phase_q[i]} + (TB+1)'(1);
			phase_nxt[i]  = (phase_inc[i] >= {1'b0, period_q[i]}) ? '0 : phase_inc[i][TB-1:0];
			ttd_nxt[i]    = (ttd_q[i] == edfts_pkg::TTD_MIN) ? ttd_q[i] : ttd_q[i] - TW'(1);
		end
	end

	// Selection tree: right child wins only on a strictly earlier deadline
	always_comb begin
		for (int k = 0; k < 2*LEAVES; k++) begin
			nd_v[k] = 1'b0;
			nd_t[k] = '0;
			nd_i[k] = '0;
		end
		for (int k = 0; k < LEAVES; k++) begin
			nd_i[LEAVES+k] = SLOT_W'(k);
			if (k < MAX_SLOTS) begin
				nd_v[LEAVES+k] = eligible[k];
				nd_t[LEAVES+k] = ttd_q[k];
			end
		end
		for (int k = LEAVES-1; k >= 1; k--) begin
			if (nd_v[2*k+1] && (!nd_v[2*k] || (nd_t[2*k+1] < nd_t[2*k]))) begin
				nd_t[k] = nd_t[2*k+1];
				nd_i[k] = nd_i[2*k+1];
			end else begin
				nd_t[k] = nd_t[2*k];
				nd_i[k] = nd_i[2*k];
			end
			nd_v[k] = nd_v[2*k] || nd_v[2*k+1];
		end
	end

	assign found = nd_v[1];
	assign pick  = nd_i[1];

	// Task tables and result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && cmd_valid && is_load) begin
			exec_q[wr_slot] <= cmd.exec_time;
			dl_q[wr_slot]   <= cmd.rel_deadline;
		end
		if (res_load) begin
			out_q.run_slot  <= found ? edfts_pkg::SLOT_FIELD_W'(pick) : '0;
			out_q.idle      <= !found;
			out_q.tick_time <= tick_q;
		end
	end

	// Scheduler state: load, release, then select and advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
			tick_q      <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				period_q[i] <= '0;
				phase_q[i]  <= '0;
				budget_q[i] <= '0;
				ttd_q[i]    <= '0;
			end
		end else begin
			// Hold the result until taken, then load the next one
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (cmd_valid) begin
						if (is_load) begin
							period_q[wr_slot] <= cmd.period;
							phase_q[wr_slot]  <= '0;
							budget_q[wr_slot] <= '0;
						end else begin
							for (int i = 0; i < MAX_SLOTS; i++) begin
								if (release_en[i]) begin
									budget_q[i] <= exec_q[i];
									ttd_q[i]    <= signed'({1'b0, dl_q[i]});
								end
							end
							state_q <= ST_PICK;
						end
					end
				end
				ST_PICK: begin
					if (res_load) begin
						for (int i = 0; i < MAX_SLOTS; i++) begin
							if (enabled[i]) begin
								phase_q[i] <= phase_nxt[i];
								ttd_q[i]   <= ttd_nxt[i];
							end
							if (found && (pick == SLOT_W'(i))) begin
								budget_q[i] <= budget_q[i] - TB'(1);
							end
						end
						tick_q      <= tick_q + edfts_pkg::TICK_W'(1);
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`EDFTS_ASSERT_IMPL(a_pop_needs_cmd, cmd_pop, cmd_valid, "engine popped an empty queue")
	`EDFTS_ASSERT_NEXT(a_tick_advance, res_load, tick_q == $past(tick_q) + 32'd1, "tick count did not advance with result")
	`EDFTS_ASSERT_IMPL(a_result_from_pick, $rose(out_valid_q), $past(state_q) == ST_PICK, "result appeared outside selection")
	`EDFTS_ASSERT_IMPL(a_idle_slot_zero, out_valid_q && out_q.idle, out_q.run_slot == '0, "idle result carries a slot")

endmodule

>>> rtl/core/edf_tick_scheduler_unit.sv
// EDF tick scheduler: a load is handled in the engine's run state; a tick is released in the run state,
// then goes to selection through the comparator tree and advance of all slots in the pick state.
// A tick's result is registered in the pick state, which pops no command and waits for a free output register.
// One load per cycle while the engine is in its run state; a two-entry queue absorbs bursts.
// Reset: arst_n clears task_count, all periods, phases, budgets, time-to-deadline values and the tick count.
// Depends on edfts_pkg, edfts_front, edfts_queue and edfts_engine.
module edf_tick_scheduler_unit #(
	parameter int MAX_SLOTS = edfts_pkg::MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [edfts_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [edfts_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [edfts_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  edfts_pkg::in_item_t               in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output edfts_pkg::out_item_t              out_item
);

	logic [edfts_pkg::TASK_COUNT_W-1:0] task_count_q;
	logic            cfg_sel;
	logic            queue_full;
	logic            push_valid;
	edfts_pkg::cmd_t push_cmd;
	logic            head_valid;
	edfts_pkg::cmd_t head_cmd;
	logic            head_pop;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[2] == edfts_pkg::REG_TASK_COUNT);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			task_count_q <= pwdata[edfts_pkg::TASK_COUNT_W-1:0];
		end
	end

	assign prdata = cfg_sel ? edfts_pkg::APB_DATA_W'(task_count_q) : '0;

	edfts_front #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	edfts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	edfts_engine #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_count (task_count_q),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (head_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

>>> verif/edf_tick_scheduler_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for edf_tick_scheduler_unit: directed table, then random load/tick phases.
// Holds its own EDF predictor and compares every tick result field by field.
// Depends on edfts_pkg and the edf_tick_scheduler_unit RTL.
module edf_tick_scheduler_unit_tb;

	localparam int NSLOTS         = edfts_pkg::MAX_SLOTS_DEF;
	localparam int TIME_W         = edfts_pkg::TIME_BITS;
	localparam int TTD_W          = edfts_pkg::TTD_W;
	localparam int TICK_W         = edfts_pkg::TICK_W;
	localparam int SLOT_W         = edfts_pkg::SLOT_FIELD_W;
	localparam int CNT_W          = edfts_pkg::TASK_COUNT_W;
	localparam int RANDOM_ITEMS   = 950;
	localparam int CALM_AFTER     = 780;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CNT_W-1:0]     count;
		edfts_pkg::in_item_t  req;
		logic                 typed;
		edfts_pkg::out_item_t res;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [edfts_pkg::APB_ADDR_W-1:0] paddr;
	logic [edfts_pkg::APB_DATA_W-1:0] pwdata;
	logic [edfts_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;
	logic                             in_valid;
	logic                             in_stall;
	edfts_pkg::in_item_t              in_item;
	logic                             out_valid;
	logic                             out_stall;
	edfts_pkg::out_item_t             out_item;

	// Predictor state
	logic [CNT_W-1:0]             task_count_cfg;
	logic [TIME_W-1:0]            exec_tbl   [NSLOTS];
	logic [TIME_W-1:0]            dl_tbl     [NSLOTS];
	logic [TIME_W-1:0]            period_tbl [NSLOTS];
	logic [TIME_W-1:0]            phase      [NSLOTS];
	logic [TIME_W-1:0]            budget     [NSLOTS];
	logic signed [TTD_W-1:0]      ttd        [NSLOTS];
	logic [TICK_W-1:0]            tick_cnt;

	edfts_pkg::out_item_t expected_picks [$];
	edfts_pkg::out_item_t head_pick;
	stim_row_t plan [$];

	int  errors;
	int  quiet_cycles;
	int  stall_left;
	int  rnd_sent;
	bit  idle_on;

	edf_tick_scheduler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// EDF step: apply one transaction, return 1 and the pick when it is a tick
	function automatic bit edf_tick_predict(input edfts_pkg::in_item_t it,
			output edfts_pkg::out_item_t pick_res);
		int  n;
		int  pick;
		bit  found;
		int  nxt;
		pick_res = '0;
		if (it.req_type == edfts_pkg::REQ_LOAD) begin
			exec_tbl[it.slot]   = it.exec_time;
			dl_tbl[it.slot]     = it.rel_deadline;
			period_tbl[it.slot] = it.period;
			phase[it.slot]      = '0;
			budget[it.slot]     = '0;
			return 1'b0;
		end
		n = (task_count_cfg > NSLOTS) ? NSLOTS : int'(task_count_cfg);
		// release slots at phase zero
		for (int i = 0; i < n; i++) begin
			if (period_tbl[i] != 0 && phase[i] == 0) begin
				budget[i] = exec_tbl[i];
				ttd[i]    = $signed({1'b0, dl_tbl[i]});
			end
		end
		// earliest deadline wins, lower slot on ties
		found = 1'b0;
		pick  = 0;
		for (int i = 0; i < n; i++) begin
			if (budget[i] != 0 && (!found || ttd[i] < ttd[pick])) begin
				pick  = i;
				found = 1'b1;
			end
		end
		if (found)
			budget[pick] = budget[pick] - 1'b1;
		// advance phases, count deadlines down with saturation
		for (int i = 0; i < n; i++) begin
			if (period_tbl[i] != 0) begin
				nxt      = int'(phase[i]) + 1;
				phase[i] = (nxt >= int'(period_tbl[i])) ? '0 : TIME_W'(nxt);
				if (ttd[i] != edfts_pkg::TTD_MIN)
					ttd[i] = ttd[i] - TTD_W'(1);
			end
		end
		pick_res.run_slot  = found ? SLOT_W'(pick) : '0;
		pick_res.idle      = !found;
		pick_res.tick_time = tick_cnt;
		tick_cnt           = tick_cnt + 1'b1;
		return 1'b1;
	endfunction

	// Drive one transaction, hold it until accepted, queue its pick
	task automatic send_req(input edfts_pkg::in_item_t it, input logic typed,
			input edfts_pkg::out_item_t typed_res);
		int                   gap;
		bit                   taken;
		edfts_pkg::out_item_t pred;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		if (edf_tick_predict(it, pred))
			expected_picks.push_back(typed ? typed_res : pred);
	endtask

	// Drop valid and wait until the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of task_count: setup cycle, then access until pready
	task automatic write_task_count(input logic [CNT_W-1:0] c);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {edfts_pkg::REG_TASK_COUNT, 2'b00};
		pwdata  <= edfts_pkg::APB_DATA_W'(c);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		task_count_cfg = c;
	endtask

	function automatic stim_row_t req_row(input logic rt, input logic [SLOT_W-1:0] s,
			input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] d,
			input logic [TIME_W-1:0] p);
		stim_row_t r;
		r                  = '0;
		r.kind             = ROW_REQ;
		r.req.req_type     = rt;
		r.req.slot         = s;
		r.req.exec_time    = e;
		r.req.rel_deadline = d;
		r.req.period       = p;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CNT_W-1:0] c);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_CFG;
		r.count = c;
		return r;
	endfunction

	// Tick with every load field at ones, known to come back idle
	function automatic stim_row_t idle_row(input logic [TICK_W-1:0] t);
		stim_row_t r;
		r               = req_row(edfts_pkg::REQ_TICK, '1, '1, '1, '1);
		r.typed         = 1'b1;
		r.res.run_slot  = '0;
		r.res.idle      = 1'b1;
		r.res.tick_time = t;
		return r;
	endfunction

	function automatic edfts_pkg::in_item_t rand_load();
		edfts_pkg::in_item_t r;
		int                  p;
		r          = '0;
		r.req_type = edfts_pkg::REQ_LOAD;
		r.slot     = SLOT_W'($urandom_range(0, NSLOTS - 1));
		if ($urandom_range(0, 7) == 0) begin
			r.exec_time    = TIME_W'($urandom);
			r.rel_deadline = TIME_W'($urandom);
			r.period       = TIME_W'($urandom);
		end else begin
			p              = $urandom_range(0, 12);
			r.period       = TIME_W'(p);
			r.exec_time    = TIME_W'($urandom_range(0, p + 1));
			r.rel_deadline = TIME_W'($urandom_range(0, p + 3));
		end
		return r;
	endfunction

	function automatic edfts_pkg::in_item_t rand_tick();
		edfts_pkg::in_item_t r;
		logic [63:0]         raw;
		raw        = {$urandom, $urandom};
		r          = raw[$bits(edfts_pkg::in_item_t)-1:0];
		r.req_type = edfts_pkg::REQ_TICK;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] rand_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return CNT_W'(NSLOTS);
			3: return CNT_W'(1);
			default: return CNT_W'($urandom_range(2, NSLOTS));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver stall: random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left <= stall_left - 1;
		else if (idle_on && $urandom_range(0, 6) == 0)
			stall_left <= $urandom_range(1, 7);
		out_stall <= (stall_left > 1) || (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0);
	end

	// Result checking and watchdog, sampled between edges
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_picks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, out_item);
				errors++;
			end else begin
				head_pick = expected_picks.pop_front();
				check_field("run_slot", 32'(head_pick.run_slot), 32'(out_item.run_slot));
				check_field("idle", 32'(head_pick.idle), 32'(out_item.idle));
				check_field("tick_time", head_pick.tick_time, out_item.tick_time);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Main sequence
	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		in_item        = '0;
		out_stall      = 1'b0;
		stall_left     = 0;
		quiet_cycles   = 0;
		errors         = 0;
		idle_on        = 1'b1;
		rnd_sent       = 0;
		task_count_cfg = '0;
		tick_cnt       = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			exec_tbl[i]   = '0;
			dl_tbl[i]     = '0;
			period_tbl[i] = '0;
			phase[i]      = '0;
			budget[i]     = '0;
			ttd[i]        = '0;
		end

		// Directed table
		plan.push_back(idle_row(0));                                   // nothing enabled after reset
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 0, 2, 3, 4));
		plan.push_back(idle_row(1));                                   // slot outside task_count
		plan.push_back(cfg_row('1));                                   // large count acts as full
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 7, 1, 1, 2));
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 3, '1, '1, '1));   // field extremes
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 5, 3, 0, 0));      // disabled slot
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 1, 2, 3, 4));      // deadline tie with slot 0
		for (int i = 0; i < 8; i++)
			plan.push_back(req_row(edfts_pkg::REQ_TICK, 3'(i), '0, '1, 16'(i)));
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 0, 0, 0, 1));      // released with no budget
		plan.push_back(req_row(edfts_pkg::REQ_LOAD, 2, 5, 0, 9));      // deadline overrun
		for (int i = 0; i < 6; i++)
			plan.push_back(req_row(edfts_pkg::REQ_TICK, '0, 16'h5555, 16'haaaa, '0));
		plan.push_back(cfg_row(0));
		plan.push_back(req_row(edfts_pkg::REQ_TICK, 0, 0, 0, 0));
		plan.push_back(cfg_row(CNT_W'(NSLOTS)));
		plan.push_back(req_row(edfts_pkg::REQ_TICK, 0, 0, 0, 0));
		plan.push_back(req_row(edfts_pkg::REQ_TICK, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_task_count(plan[i].count);
			end else begin
				send_req(plan[i].req, plan[i].typed, plan[i].res);
			end
		end

		// Random phases: reprogram, seed some tasks, then mostly ticks
		while (rnd_sent < RANDOM_ITEMS) begin
			settle();
			idle_on = (rnd_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			write_task_count(rand_count());
			repeat ($urandom_range(1, 5)) begin
				send_req(rand_load(), 1'b0, '0);
				rnd_sent++;
			end
			repeat ($urandom_range(20, 60)) begin
				if ($urandom_range(0, 99) < 85)
					send_req(rand_tick(), 1'b0, '0);
				else
					send_req(rand_load(), 1'b0, '0);
				rnd_sent++;
			end
		end

		// Drain and finish
		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
